### rtl/rvmd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rvmd_pkg: shared types and constants
// Operation codes, data widths and the record that travels down the
// divider pipeline.
// ----------------------------------------------------------------------------
package rvmd_pkg;

  localparam int XLEN      = 32;
  localparam int NUM_STEPS = XLEN;  // one quotient bit per divider stage

  localparam logic [2:0] OP_MULHSU = 3'b010;
  localparam logic [2:0] OP_DIV    = 3'b100;
  localparam logic [2:0] OP_DIVU   = 3'b101;
  localparam logic [2:0] OP_REM    = 3'b110;
  localparam logic [2:0] OP_REMU   = 3'b111;

  localparam logic [XLEN-1:0] ALL_ONES = '1;

  // One in-flight item. rem/quo form the shifting partial remainder and
  // dividend/quotient register pair of a restoring divider.
  typedef struct packed {
    logic            valid;
    logic            illegal;
    logic            use_fixed;  // result is taken from fixed, not the divider
    logic [XLEN-1:0] fixed;
    logic            want_rem;
    logic            neg_result;
    logic [XLEN-1:0] rem;
    logic [XLEN-1:0] quo;
    logic [XLEN-1:0] divisor;
  } stage_t;

endpackage
`default_nettype wire

### rtl/rvmd_pre.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rvmd_pre: operand preparation
// Two register stages: capture operands and the unsigned product, then
// decode, take magnitudes, finish MULHSU and resolve divide by zero.
// ----------------------------------------------------------------------------
module rvmd_pre
  import rvmd_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire logic [2:0]      operation,
  input  wire logic [XLEN-1:0] operand_a,
  input  wire logic [XLEN-1:0] operand_b,
  output stage_t               out
);

  logic              cap_valid;
  logic [2:0]        cap_op;
  logic [XLEN-1:0]   cap_a;
  logic [XLEN-1:0]   cap_b;
  logic [2*XLEN-1:0] cap_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_valid <= 1'b0;
    end else begin
      cap_valid <= in_valid;
    end
    cap_op   <= operation;
    cap_a    <= operand_a;
    cap_b    <= operand_b;
    cap_prod <= (2*XLEN)'(operand_a) * (2*XLEN)'(operand_b);
  end

  stage_t          out_next;
  logic            is_mul;
  logic            is_div;
  logic            is_signed;
  logic            na;
  logic            nb;
  logic [XLEN-1:0] mul_hi;

  always_comb begin
    is_mul    = (cap_op == OP_MULHSU);
    is_div    = (cap_op == OP_DIV) || (cap_op == OP_DIVU) ||
                (cap_op == OP_REM) || (cap_op == OP_REMU);
    is_signed = (cap_op == OP_DIV) || (cap_op == OP_REM);
    na        = is_signed & cap_a[XLEN-1];
    nb        = is_signed & cap_b[XLEN-1];
    // Signed rs1 times unsigned rs2: drop b from the upper half when rs1 < 0.
    mul_hi    = cap_prod[2*XLEN-1:XLEN] - (cap_a[XLEN-1] ? cap_b : '0);

    out_next            = '0;
    out_next.valid      = cap_valid;
    out_next.illegal    = !(is_mul || is_div);
    out_next.want_rem   = cap_op[1];
    out_next.neg_result = cap_op[1] ? na : (na ^ nb);
    out_next.rem        = '0;
    out_next.quo        = na ? (XLEN'(0) - cap_a) : cap_a;
    out_next.divisor    = nb ? (XLEN'(0) - cap_b) : cap_b;
    // Signed overflow needs no special path: |min| / 1 is min unchanged, rem 0.
    if (is_mul) begin
      out_next.use_fixed = 1'b1;
      out_next.fixed     = mul_hi;
    end else if (!is_div) begin
      out_next.use_fixed = 1'b1;
      out_next.fixed     = '0;
    end else if (cap_b == '0) begin
      out_next.use_fixed = 1'b1;
      out_next.fixed     = cap_op[1] ? cap_a : ALL_ONES;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid <= 1'b0;
    end else begin
      out.valid <= out_next.valid;
    end
    out.illegal    <= out_next.illegal;
    out.use_fixed  <= out_next.use_fixed;
    out.fixed      <= out_next.fixed;
    out.want_rem   <= out_next.want_rem;
    out.neg_result <= out_next.neg_result;
    out.rem        <= out_next.rem;
    out.quo        <= out_next.quo;
    out.divisor    <= out_next.divisor;
  end

endmodule
`default_nettype wire

### rtl/rvmd_div_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rvmd_div_step: one restoring division stage
// Shift one dividend bit into the partial remainder, trial-subtract the
// divisor and record one quotient bit.
// ----------------------------------------------------------------------------
module rvmd_div_step
  import rvmd_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire stage_t in,
  output stage_t      out
);

  logic [XLEN:0] shifted;
  logic [XLEN:0] diff;
  logic          fits;

  always_comb begin
    shifted = {in.rem, in.quo[XLEN-1]};
    diff    = shifted - {1'b0, in.divisor};
    fits    = !diff[XLEN];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid <= 1'b0;
    end else begin
      out.valid <= in.valid;
    end
    out.illegal    <= in.illegal;
    out.use_fixed  <= in.use_fixed;
    out.fixed      <= in.fixed;
    out.want_rem   <= in.want_rem;
    out.neg_result <= in.neg_result;
    out.divisor    <= in.divisor;
    out.rem        <= fits ? diff[XLEN-1:0] : shifted[XLEN-1:0];
    out.quo        <= {in.quo[XLEN-2:0], fits};
  end

endmodule
`default_nettype wire

### rtl/rvmd_post.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rvmd_post: result selection
// Pick quotient, remainder or the precomputed value, fix the sign and
// register the result strobe.
// ----------------------------------------------------------------------------
module rvmd_post
  import rvmd_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire stage_t          in,
  output logic                 done,
  output logic [XLEN-1:0]      result,
  output logic                 illegal
);

  logic [XLEN-1:0] raw;
  logic [XLEN-1:0] result_next;

  always_comb begin
    raw = in.want_rem ? in.rem : in.quo;
    if (in.use_fixed) begin
      result_next = in.fixed;
    end else if (in.neg_result) begin
      result_next = XLEN'(0) - raw;
    end else begin
      result_next = raw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in.valid;
    end
    result  <= result_next;
    illegal <= in.illegal;
  end

endmodule
`default_nettype wire

### rtl/rv32m_divide_mulhsu_unit_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rv32m_divide_mulhsu_unit_top: RV32M divide and MULHSU execute unit
// Fully pipelined MULHSU / DIV / DIVU / REM / REMU with one result per item.
// ----------------------------------------------------------------------------
// Usage:
//   Drive operation (funct3), operand_a (rs1) and operand_b (rs2) and raise
//   start; the transfer happens at the clock edge where start is high and
//   busy is low. busy is always low: the pipeline takes a new item every
//   cycle, so start may stay high for back-to-back transfers.
//   Each item returns one result on result/illegal, marked by done for
//   exactly one cycle, after the item has passed through two stages of operand
//   preparation (unsigned 32x32 product, then magnitudes and MULHSU
//   correction), 32 restoring-division stages at one quotient bit each,
//   and one output stage for sign fix and selection. Results leave in the
//   order items entered.
//   Throughput is one item per cycle; every operation, MULHSU included,
//   passes through all 32 division stages.
//   Divide by zero gives all ones (DIV/DIVU) or the dividend (REM/REMU);
//   0x80000000 / -1 gives the dividend for DIV and 0 for REM. Codes other
//   than the five handled give result 0 with illegal set.
//   Synchronous reset clears all valid bits, dropping items in flight.
//   The receiver cannot stall: it must take each result in its done cycle.
// ----------------------------------------------------------------------------
module rv32m_divide_mulhsu_unit_top
  import rvmd_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  output logic                 busy,
  input  wire logic [2:0]      operation,
  input  wire logic [XLEN-1:0] operand_a,
  input  wire logic [XLEN-1:0] operand_b,
  output logic                 done,
  output logic [XLEN-1:0]      result,
  output logic                 illegal
);

  // Nothing ever holds the pipeline, so the unit never refuses a transfer.
  assign busy = 1'b0;

  // pipe[0] leaves operand preparation; pipe[i+1] leaves division stage i.
  stage_t pipe [0:NUM_STEPS];

  rvmd_pre u_pre (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start & ~busy),
    .operation (operation),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .out       (pipe[0])
  );

  // Advance one quotient bit per stage, most significant first.
  for (genvar i = 0; i < NUM_STEPS; i++) begin : g_step
    rvmd_div_step u_step (
      .clk (clk),
      .rst (rst),
      .in  (pipe[i]),
      .out (pipe[i+1])
    );
  end

  rvmd_post u_post (
    .clk     (clk),
    .rst     (rst),
    .in      (pipe[NUM_STEPS]),
    .done    (done),
    .result  (result),
    .illegal (illegal)
  );

endmodule
`default_nettype wire

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the RV32M divide / MULHSU execute unit
// Sends a short table of corner-case instructions and then 2000 random ones
// through the command port. The bench computes each answer no typed row gives,
// queues every answer in transfer order and compares it with each done strobe.
// ----------------------------------------------------------------------------
module tb_top
  import rvmd_pkg::*;
();

  // funct3 codes the unit does not handle; they must come back flagged
  localparam logic [2:0] OP_MUL   = 3'b000;
  localparam logic [2:0] OP_MULH  = 3'b001;
  localparam logic [2:0] OP_MULHU = 3'b011;

  localparam logic [XLEN-1:0] MIN_NEG = 32'h8000_0000;
  localparam logic [XLEN-1:0] MAX_POS = 32'h7FFF_FFFF;

  localparam int RANDOM_ITEMS = 2000;
  localparam int NUM_PHASES   = 4;
  localparam int DRAIN_CYCLES = 60;  // pipeline is 35 deep; allow some slack

  // One answer of the unit
  typedef struct packed {
    logic [XLEN-1:0] result;
    logic            illegal;
  } rv_answer_t;

  // One row of the directed table; typed rows carry their answer inline
  typedef struct packed {
    logic [2:0]      op;
    logic [XLEN-1:0] a;
    logic [XLEN-1:0] b;
    logic            typed;
    rv_answer_t      answer;
  } corner_row_t;

  logic            clk       = 1'b0;
  logic            rst       = 1'b1;
  logic            start     = 1'b0;
  logic [2:0]      operation = OP_MUL;
  logic [XLEN-1:0] operand_a = '0;
  logic [XLEN-1:0] operand_b = '0;
  logic            busy;
  logic            done;
  logic [XLEN-1:0] result;
  logic            illegal;

  // Typed answer that travels with the instruction currently offered
  logic            cur_typed  = 1'b0;
  rv_answer_t      cur_answer = '0;

  rv_answer_t      answers_due[$];
  rv_answer_t      oldest;
  int              fail_count = 0;

  rv32m_divide_mulhsu_unit_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .operation (operation),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .done      (done),
    .result    (result),
    .illegal   (illegal)
  );

  always #5 clk = ~clk;

  // Hard stop in case the unit hangs or drops results
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Answer computation, written directly in RISC-V terms
  // --------------------------------------------------------------------------
  function automatic rv_answer_t compute_rv32m(input logic [2:0] op,
                                               input logic [XLEN-1:0] a,
                                               input logic [XLEN-1:0] b);
    rv_answer_t      ans;
    logic [63:0]     product;
    ans = '0;
    case (op)
      OP_MULHSU: begin
        // sign-extend rs1, zero-extend rs2; low 64 bits are exact either way
        product    = {{32{a[31]}}, a} * {32'h0, b};
        ans.result = product[63:32];
      end
      OP_DIV: begin
        if (b == '0) ans.result = ALL_ONES;
        else if (a == MIN_NEG && b == ALL_ONES) ans.result = a;
        else ans.result = $signed(a) / $signed(b);
      end
      OP_REM: begin
        if (b == '0) ans.result = a;
        else if (a == MIN_NEG && b == ALL_ONES) ans.result = '0;
        else ans.result = $signed(a) % $signed(b);
      end
      OP_DIVU: ans.result = (b == '0) ? ALL_ONES : a / b;
      OP_REMU: ans.result = (b == '0) ? a : a % b;
      default: ans.illegal = 1'b1;
    endcase
    return ans;
  endfunction

  // Bias operands toward the values where dividers tend to break
  function automatic logic [XLEN-1:0] pick_operand();
    logic [XLEN-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom;
      4: begin
        case ($urandom_range(0, 5))
          0: v = '0;
          1: v = 32'd1;
          2: v = ALL_ONES;
          3: v = MIN_NEG;
          4: v = MAX_POS;
          default: v = MIN_NEG + 32'd1;
        endcase
      end
      5, 6: v = $urandom_range(0, 15);
      7: v = 32'd0 - $urandom_range(1, 15);
      default: v = $urandom >> $urandom_range(0, 31);
    endcase
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // Result checker: pop the oldest answer on each done, then queue the
  // answer of any instruction transferred at this edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        if (answers_due.size() == 0) begin
          $error("unexpected result: result=%h illegal=%b", result, illegal);
          fail_count++;
        end else begin
          oldest = answers_due.pop_front();
          if (result !== oldest.result) begin
            $error("result mismatch: expected %h, actual %h", oldest.result, result);
            fail_count++;
          end
          if (illegal !== oldest.illegal) begin
            $error("illegal mismatch: expected %b, actual %b", oldest.illegal, illegal);
            fail_count++;
          end
        end
      end
      if (start && !busy)
        answers_due.push_back(cur_typed ? cur_answer
                                        : compute_rv32m(operation, operand_a, operand_b));
    end
  end

  // --------------------------------------------------------------------------
  // Offer one instruction: idle for the given gap, then hold start until the
  // transfer. With no gap start stays high, so back-to-back items never see
  // start lowered and raised in the same step.
  // --------------------------------------------------------------------------
  task automatic send_instr(input logic [2:0] op, input logic [XLEN-1:0] a,
                            input logic [XLEN-1:0] b, input logic typed,
                            input rv_answer_t answer, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    operation  <= op;
    operand_a  <= a;
    operand_b  <= b;
    cur_typed  <= typed;
    cur_answer <= answer;
    do @(posedge clk); while (busy);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    corner_row_t     corners[$];
    int              idle_pct[NUM_PHASES];
    int              gap;
    logic [2:0]      op;
    logic [XLEN-1:0] a;
    logic [XLEN-1:0] b;

    // Sender idle percentage per random phase: none, heavy, moderate, none
    idle_pct = '{0, 76, 32, 0};

    // Typed rows: zero, divide by zero, signed overflow, trivial divisors,
    // unhandled codes. The rest are left to the computed answer.
    corners.push_back({OP_MULHSU, 32'h0,    32'h0,    1'b1, 32'h0,    1'b0});
    corners.push_back({OP_MULHSU, ALL_ONES, ALL_ONES, 1'b0, 32'h0,    1'b0});
    corners.push_back({OP_MULHSU, MIN_NEG,  ALL_ONES, 1'b0, 32'h0,    1'b0});
    corners.push_back({OP_MULHSU, MAX_POS,  ALL_ONES, 1'b0, 32'h0,    1'b0});
    corners.push_back({OP_MULHSU, MIN_NEG,  32'h1,    1'b0, 32'h0,    1'b0});
    corners.push_back({OP_DIV,    MAX_POS,  32'h0,    1'b1, ALL_ONES, 1'b0});
    corners.push_back({OP_DIVU,   ALL_ONES, 32'h0,    1'b1, ALL_ONES, 1'b0});
    corners.push_back({OP_REM,    MIN_NEG,  32'h0,    1'b1, MIN_NEG,  1'b0});
    corners.push_back({OP_REMU,   ALL_ONES, 32'h0,    1'b1, ALL_ONES, 1'b0});
    corners.push_back({OP_DIV,    MIN_NEG,  ALL_ONES, 1'b1, MIN_NEG,  1'b0});
    corners.push_back({OP_REM,    MIN_NEG,  ALL_ONES, 1'b1, 32'h0,    1'b0});
    // rounding toward zero and remainder sign follows the dividend
    corners.push_back({OP_DIV,    -32'sd7,  32'd2,    1'b0, 32'h0,    1'b0});
    corners.push_back({OP_REM,    -32'sd7,  32'd2,    1'b0, 32'h0,    1'b0});
    corners.push_back({OP_REM,    32'd7,    -32'sd2,  1'b0, 32'h0,    1'b0});
    corners.push_back({OP_DIV,    MIN_NEG,  32'h1,    1'b0, 32'h0,    1'b0});
    corners.push_back({OP_DIV,    ALL_ONES, ALL_ONES, 1'b1, 32'h1,    1'b0});
    corners.push_back({OP_DIVU,   ALL_ONES, 32'h1,    1'b1, ALL_ONES, 1'b0});
    corners.push_back({OP_REMU,   ALL_ONES, 32'h1,    1'b1, 32'h0,    1'b0});
    corners.push_back({OP_DIVU,   32'h0,    ALL_ONES, 1'b1, 32'h0,    1'b0});
    corners.push_back({OP_REMU,   MAX_POS,  MIN_NEG,  1'b1, MAX_POS,  1'b0});
    corners.push_back({OP_MUL,    ALL_ONES, ALL_ONES, 1'b1, 32'h0,    1'b1});
    corners.push_back({OP_MULH,   ALL_ONES, ALL_ONES, 1'b1, 32'h0,    1'b1});
    corners.push_back({OP_MULHU,  ALL_ONES, ALL_ONES, 1'b1, 32'h0,    1'b1});

    // Hold reset, then release it for good
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part, back to back with an occasional gap
    foreach (corners[i])
      send_instr(corners[i].op, corners[i].a, corners[i].b, corners[i].typed,
                 corners[i].answer, (i % 5 == 4) ? 1 : 0);

    // Random part, split into idling phases
    for (int p = 0; p < NUM_PHASES; p++) begin
      for (int n = 0; n < RANDOM_ITEMS / NUM_PHASES; n++) begin
        // mostly handled codes, with all eight funct3 values now and then
        if ($urandom_range(0, 9) < 8) begin
          case ($urandom_range(0, 4))
            0: op = OP_MULHSU;
            1: op = OP_DIV;
            2: op = OP_DIVU;
            3: op = OP_REM;
            default: op = OP_REMU;
          endcase
        end else begin
          op = 3'($urandom_range(0, 7));
        end
        a   = pick_operand();
        b   = pick_operand();
        // idle each cycle with the phase's percentage before offering
        gap = 0;
        while ($urandom_range(0, 99) < idle_pct[p]) gap++;
        send_instr(op, a, b, 1'b0, '0, gap);
      end
    end
    start <= 1'b0;

    // Drain: wait for every queued answer, then watch for stray strobes
    while (answers_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### rv32m_divide_mulhsu_unit_top.f
rtl/rvmd_pkg.sv
rtl/rvmd_pre.sv
rtl/rvmd_div_step.sv
rtl/rvmd_post.sv
rtl/rv32m_divide_mulhsu_unit_top.sv
dv/tb_top.sv
